// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of clk while the active-low reset rst_n is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that cond never holds at a rising edge of clk outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/mrcs_pkg.sv
// Package with the types and constants of the matrix row and column scaling core.
`timescale 1ns / 1ps
`default_nettype none

package mrcs_pkg;

	localparam int DATA_W = 32;
	localparam int MAG_W  = 31;

	localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [DATA_W-1:0] SAT_Q16 = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] MIN_ENTRY = 32'h8000_0000;

	// A scale s is far from 1.0 when 10 * |s - 1.0| exceeds 1.0, that is when the
	// distance is above 6553 LSBs: s below 58983 or s above 72089.
	localparam logic [DATA_W-1:0] FAR_LO_Q16 = 32'd58983;
	localparam logic [DATA_W-1:0] FAR_HI_Q16 = 32'd72089;

	localparam int RECIP_STEPS = 32;
	localparam int STEP_W = 6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UPDATE,
		S_SCAN_RD,
		S_ROW_GO,
		S_ROW_WAIT,
		S_COL_GO,
		S_COL_WAIT,
		S_EMIT_RD,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
	} recip_rsp_t;

endpackage

`default_nettype wire

// File: rtl/mrcs_ram.sv
// Single-port memory with a registered read, holding peaks and then scales.
`timescale 1ns / 1ps
`default_nettype none

module mrcs_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                       wr_data,
	output logic      [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
		rd_data <= mem_q[addr];
	end

endmodule

`default_nettype wire

// File: rtl/mrcs_recip.sv
// Bit-serial reciprocal unit: floor(2^32 / peak) in unsigned Q16.16 (1.0 for a zero peak), one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module mrcs_recip import mrcs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [MAG_W-1:0] operand,
	output recip_rsp_t            rsp
);

	logic [DATA_W-1:0] rem_q;
	logic [MAG_W-1:0]  div_q;
	logic [DATA_W-1:0] quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DATA_W-1:0] shifted;
	logic              fits;

	// The remainder stays below the divisor, which is below 2^31, so the shift never overflows.
	assign shifted = {rem_q[DATA_W-2:0], 1'b0};
	assign fits    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (operand == '0 || operand == MAG_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					cnt_q <= STEP_W'(RECIP_STEPS);
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= operand;
			// Quotient bit 32 is set only for a divisor of one, which saturates.
			rem_q <= DATA_W'(1);
			if (operand == '0) begin
				quo_q <= ONE_Q16;
			end else if (operand == MAG_W'(1)) begin
				quo_q <= SAT_Q16;
			end else begin
				quo_q <= '0;
			end
		end else if (run_q) begin
			if (fits) begin
				rem_q <= shifted - {1'b0, div_q};
			end else begin
				rem_q <= shifted;
			end
			quo_q <= {quo_q[DATA_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// File: rtl/matrix_row_column_scaling_core.sv
// Top level of the matrix row and column scaling core: sequencer, peak stores and outputs.
//
//  Channel   Handshake                      Payload
//  -------   ----------------------------   ----------------------------------------------
//  entry     start, busy                    matrix_entry
//  config    cfg_valid, cfg_ready           cfg_data (matrix_size)
//  result    result_strobe                  scale_index, row_scale, column_scale,
//                                           rescale_flag, last_result
//
// For each matrix entry the row and column peaks are read in S_IDLE and written back in
// S_UPDATE. After the last entry, each index k takes a read state plus two passes of the
// serial reciprocal unit (row peak, then column peak, each up to a 32-step divide loop), and
// the n results then follow, with S_EMIT_RD and S_EMIT alternating so no two are adjacent.
// Reset (arst_n low) sets n to MAX_SIZE and marks every peak as zero; no clearing pass runs.
// The receiver cannot stall: each result is valid for exactly the one strobe cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module matrix_row_column_scaling_core import mrcs_pkg::*; #(
	parameter int MAX_SIZE = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic signed [31:0] matrix_entry,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [4:0]        cfg_data,
	output logic                   result_strobe,
	output logic [3:0]             scale_index,
	output logic [31:0]            row_scale,
	output logic [31:0]            column_scale,
	output logic                   rescale_flag,
	output logic                   last_result
);

	localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

	state_t state_q, state_d;

	// Matrix position of the next entry, scan index and the active last index n-1.
	logic [IDX_W-1:0] row_q, col_q, k_q, last_idx_q;
	logic [MAX_SIZE-1:0] row_vld_q, col_vld_q;
	logic [MAG_W-1:0] mag_q;
	logic needed_q;

	logic cfg_wr;
	logic accept;
	logic last_entry;
	logic last_k;

	logic [IDX_W-1:0] row_addr, col_addr;
	logic [DATA_W-1:0] row_rd, col_rd;
	logic [DATA_W-1:0] row_cur, col_cur;
	logic row_wr, col_wr;
	logic [DATA_W-1:0] row_wdata, col_wdata;

	logic div_start;
	logic [MAG_W-1:0] div_operand;
	recip_rsp_t div_rsp;
	logic div_far;

	logic [MAG_W-1:0] entry_mag;

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign accept     = start && !busy;
	assign last_entry = (row_q == last_idx_q) && (col_q == last_idx_q);
	assign last_k     = (k_q == last_idx_q);

	// The most negative entry has no positive twin in 32 bits, so its magnitude saturates.
	always_comb begin
		if (!matrix_entry[31]) begin
			entry_mag = matrix_entry[MAG_W-1:0];
		end else if (matrix_entry == MIN_ENTRY) begin
			entry_mag = '1;
		end else begin
			entry_mag = MAG_W'(~matrix_entry + 32'sd1);
		end
	end

	// A location whose valid bit is clear reads as a zero peak.
	assign row_cur = row_vld_q[row_addr] ? row_rd : '0;
	assign col_cur = col_vld_q[col_addr] ? col_rd : '0;

	assign div_far = (div_rsp.quotient < FAR_LO_Q16) || (div_rsp.quotient > FAR_HI_Q16);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				state_d = last_entry ? S_SCAN_RD : S_IDLE;
			end
			S_SCAN_RD:  state_d = S_ROW_GO;
			S_ROW_GO:   state_d = S_ROW_WAIT;
			S_ROW_WAIT: begin
				if (div_rsp.done) begin
					state_d = S_COL_GO;
				end
			end
			S_COL_GO:   state_d = S_COL_WAIT;
			S_COL_WAIT: begin
				if (div_rsp.done) begin
					state_d = last_k ? S_EMIT_RD : S_SCAN_RD;
				end
			end
			S_EMIT_RD:  state_d = S_EMIT;
			S_EMIT: begin
				state_d = last_k ? S_IDLE : S_EMIT_RD;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// Output and datapath control decoded from the state.
	always_comb begin
		busy        = 1'b1;
		row_addr    = k_q;
		col_addr    = k_q;
		row_wr      = 1'b0;
		col_wr      = 1'b0;
		row_wdata   = div_rsp.quotient;
		col_wdata   = div_rsp.quotient;
		div_start   = 1'b0;
		div_operand = row_cur[MAG_W-1:0];
		result_strobe = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				row_addr = row_q;
				col_addr = col_q;
			end
			S_UPDATE: begin
				row_addr  = row_q;
				col_addr  = col_q;
				row_wdata = {1'b0, mag_q};
				col_wdata = {1'b0, mag_q};
				row_wr    = {1'b0, mag_q} > row_cur;
				col_wr    = {1'b0, mag_q} > col_cur;
			end
			S_ROW_GO: begin
				div_start   = 1'b1;
				div_operand = row_cur[MAG_W-1:0];
			end
			S_ROW_WAIT: begin
				row_wr = div_rsp.done;
			end
			S_COL_GO: begin
				div_start   = 1'b1;
				div_operand = col_cur[MAG_W-1:0];
			end
			S_COL_WAIT: begin
				col_wr = div_rsp.done;
			end
			S_EMIT: begin
				result_strobe = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			row_q      <= '0;
			col_q      <= '0;
			k_q        <= '0;
			last_idx_q <= IDX_W'(MAX_SIZE - 1);
			row_vld_q  <= '0;
			col_vld_q  <= '0;
			needed_q   <= 1'b0;
		end else if (cfg_wr) begin
			// A size write restarts the matrix from a clean slate.
			state_q   <= S_IDLE;
			row_q     <= '0;
			col_q     <= '0;
			k_q       <= '0;
			row_vld_q <= '0;
			col_vld_q <= '0;
			needed_q  <= 1'b0;
			if (cfg_data == 5'd0) begin
				last_idx_q <= '0;
			end else if (int'(cfg_data) > MAX_SIZE) begin
				last_idx_q <= IDX_W'(MAX_SIZE - 1);
			end else begin
				last_idx_q <= IDX_W'(cfg_data - 5'd1);
			end
		end else begin
			state_q <= state_d;
			if (row_wr) begin
				row_vld_q[row_addr] <= 1'b1;
			end
			if (col_wr) begin
				col_vld_q[col_addr] <= 1'b1;
			end
			unique case (state_q)
				S_UPDATE: begin
					if (col_q == last_idx_q) begin
						col_q <= '0;
						row_q <= (row_q == last_idx_q) ? '0 : row_q + IDX_W'(1);
					end else begin
						col_q <= col_q + IDX_W'(1);
					end
					k_q      <= '0;
					needed_q <= 1'b0;
				end
				S_ROW_WAIT: begin
					if (div_rsp.done && div_far) begin
						needed_q <= 1'b1;
					end
				end
				S_COL_WAIT: begin
					if (div_rsp.done) begin
						if (div_far) begin
							needed_q <= 1'b1;
						end
						k_q <= last_k ? '0 : k_q + IDX_W'(1);
					end
				end
				S_EMIT: begin
					if (last_k) begin
						// The matrix is done: every peak reads as zero again.
						row_vld_q <= '0;
						col_vld_q <= '0;
						k_q       <= '0;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= entry_mag;
		end
	end

	mrcs_ram #(
		.DEPTH (MAX_SIZE),
		.WIDTH (DATA_W)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (row_wr),
		.addr    (row_addr),
		.wr_data (row_wdata),
		.rd_data (row_rd)
	);

	mrcs_ram #(
		.DEPTH (MAX_SIZE),
		.WIDTH (DATA_W)
	) u_col_ram (
		.clk     (clk),
		.wr_en   (col_wr),
		.addr    (col_addr),
		.wr_data (col_wdata),
		.rd_data (col_rd)
	);

	// One shared serial divider turns every row and column peak into its scale.
	mrcs_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.operand (div_operand),
		.rsp     (div_rsp)
	);

	// By the emit phase both stores hold scales at every index up to n-1.
	assign scale_index    = 4'(k_q);
	assign row_scale      = row_rd;
	assign column_scale   = col_rd;
	assign rescale_flag   = needed_q;
	assign last_result    = last_k;

	// An accepted entry keeps the block busy for its write-back cycle.
	`ASSERT_CLK(a_accept_busy, clk, arst_n, (start && !busy && !cfg_valid) |=> busy, "accept did not set busy")
	// Results are only delivered while the block is busy with a matrix.
	`ASSERT_NEVER(a_strobe_idle, clk, arst_n, result_strobe && !busy, "result strobe while idle")
	// Two results never come in adjacent cycles.
	`ASSERT_CLK(a_strobe_gap, clk, arst_n, result_strobe |=> !result_strobe, "back-to-back result strobes")
	// After the final result the block returns to idle.
	`ASSERT_CLK(a_last_idle, clk, arst_n, (result_strobe && last_result) |=> !busy, "busy after last result")

endmodule

`default_nettype wire
